// ===== sv/typed_frame_receiver_unit_assert.svh =====
// Assertion macros used by the typed frame receiver port-level checker.
`ifndef TYPED_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define TYPED_FRAME_RECEIVER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tfr: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tfr: next-cycle check failed");

`endif

// ===== sv/tfr_pkg.sv =====
// Types and constants shared by the typed frame receiver modules.
package tfr_pkg;

  localparam int BYTE_W     = 8;
  localparam int SLOT_W     = 3;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = 3;
  localparam int PAY_BYTES  = NUM_WORDS * (WORD_W / BYTE_W);
  localparam int TYPE_TBL_W = 64;
  localparam int LEN_TBL_W  = 32;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // Register reset values.
  localparam logic [BYTE_W-1:0]     START_CODE_RST = 8'h02;
  localparam logic [BYTE_W-1:0]     END_CODE_RST   = 8'h03;
  localparam logic [TYPE_TBL_W-1:0] TYPE_TBL_RST   = 64'h0;
  localparam logic [LEN_TBL_W-1:0]  LEN_TBL_RST    = 32'h4111_1C8C;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE   = 2'd0,
    REG_END_CODE     = 2'd1,
    REG_TYPE_TABLE   = 2'd2,
    REG_LENGTH_TABLE = 2'd3
  } cfg_reg_t;

  // Frame tracking states.
  typedef enum logic [2:0] {
    ST_HUNT = 3'b001,
    ST_TYPE = 3'b010,
    ST_DATA = 3'b100
  } fsm_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0]     start_code;
    logic [BYTE_W-1:0]     end_code;
    logic [TYPE_TBL_W-1:0] type_table;
    logic [LEN_TBL_W-1:0]  length_table;
  } cfg_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [LEN_W-1:0]  length;
  } match_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_index;
    logic [BYTE_W-1:0] type_code;
    logic [WORD_W-1:0] payload_word0;
    logic [WORD_W-1:0] payload_word1;
    logic [WORD_W-1:0] payload_word2;
  } result_t;

endpackage

// ===== sv/tfr_in_if.sv =====
// Input byte channel of the typed frame receiver.
interface tfr_in_if;
  import tfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== sv/tfr_out_if.sv =====
// Result channel of the typed frame receiver.
interface tfr_out_if;
  import tfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot_index;
  logic [BYTE_W-1:0] type_code;
  logic [WORD_W-1:0] payload_word0;
  logic [WORD_W-1:0] payload_word1;
  logic [WORD_W-1:0] payload_word2;

  modport source (output valid, output slot_index, output type_code,
                  output payload_word0, output payload_word1, output payload_word2,
                  input ready);
  modport sink (input valid, input slot_index, input type_code,
                input payload_word0, input payload_word1, input payload_word2,
                output ready);
endinterface

// ===== sv/tfr_cfg_regs.sv =====
// Configuration registers of the typed frame receiver.
module tfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tfr_pkg::cfg_t                  cfg
);
  import tfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write into the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_START_CODE:   cfg_nxt.start_code   = cfg_wdata[BYTE_W-1:0];
        REG_END_CODE:     cfg_nxt.end_code     = cfg_wdata[BYTE_W-1:0];
        REG_TYPE_TABLE:   cfg_nxt.type_table   = cfg_wdata[TYPE_TBL_W-1:0];
        REG_LENGTH_TABLE: cfg_nxt.length_table = cfg_wdata[LEN_TBL_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code   <= START_CODE_RST;
      cfg_r.end_code     <= END_CODE_RST;
      cfg_r.type_table   <= TYPE_TBL_RST;
      cfg_r.length_table <= LEN_TBL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/tfr_slot_match.sv =====
// Type slot lookup: finds the lowest slot whose type code equals the byte.
module tfr_slot_match #(
  parameter int NUM_SLOTS = 8
) (
  input  logic [tfr_pkg::TYPE_TBL_W-1:0] type_table,
  input  logic [tfr_pkg::LEN_TBL_W-1:0]  length_table,
  input  logic [tfr_pkg::BYTE_W-1:0]     rx_byte,
  output tfr_pkg::match_t                match
);
  import tfr_pkg::*;

  // Scan from the top slot down so that the lowest hit is kept.
  always_comb begin
    match = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (type_table[BYTE_W*i +: BYTE_W] == rx_byte) begin
        match.hit    = 1'b1;
        match.slot   = SLOT_W'(i);
        match.length = length_table[LEN_W*i +: LEN_W];
      end
    end
  end

endmodule

// ===== sv/tfr_frame_fsm.sv =====
// Frame state tracker and payload store of the typed frame receiver.
module tfr_frame_fsm #(
  parameter int MAX_PAYLOAD = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  logic [tfr_pkg::BYTE_W-1:0] rx_byte,
  input  tfr_pkg::cfg_t              cfg,
  input  tfr_pkg::match_t            match,
  output logic                       emit,
  output tfr_pkg::result_t           result
);
  import tfr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  fsm_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [BYTE_W-1:0] type_r, type_nxt;
  logic [CNT_W-1:0]  len_clamped;
  logic              clear_store;
  logic              store_we;
  logic [BYTE_W-1:0] store_r [MAX_PAYLOAD];
  logic [PAY_BYTES-1:0][BYTE_W-1:0] packed_bytes;

  // Slot lengths above the store size are cut down to it.
  assign len_clamped = (int'(match.length) > MAX_PAYLOAD) ? CNT_W'(MAX_PAYLOAD)
                                                          : CNT_W'(match.length);

  // Next state for one byte.
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    len_nxt     = len_r;
    slot_nxt    = slot_r;
    type_nxt    = type_r;
    clear_store = 1'b0;
    store_we    = 1'b0;
    emit        = 1'b0;
    if (step) begin
      unique case (state_r)
        ST_HUNT: begin
          if (rx_byte == cfg.start_code) begin
            state_nxt   = ST_TYPE;
            clear_store = 1'b1;
          end
        end
        ST_TYPE: begin
          if (match.hit) begin
            state_nxt = ST_DATA;
            count_nxt = '0;
            len_nxt   = len_clamped;
            slot_nxt  = match.slot;
            type_nxt  = rx_byte;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        ST_DATA: begin
          if (count_r >= len_r) begin
            // Closing byte: a frame counts only when it ends on the end code.
            emit      = (rx_byte == cfg.end_code);
            state_nxt = ST_HUNT;
          end else begin
            store_we  = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        default: state_nxt = ST_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      count_r <= '0;
      len_r   <= '0;
      slot_r  <= '0;
      type_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      len_r   <= len_nxt;
      slot_r  <= slot_nxt;
      type_r  <= type_nxt;
    end
  end

  // Payload store: cleared at each start code, written one byte at a time.
  always_ff @(posedge clk) begin
    if (clear_store) begin
      for (int i = 0; i < MAX_PAYLOAD; i++) begin
        store_r[i] <= '0;
      end
    end else if (store_we) begin
      store_r[count_r[IDX_W-1:0]] <= rx_byte;
    end
  end

  // Bytes beyond the store read as zero.
  for (genvar g = 0; g < PAY_BYTES; g++) begin : g_pack
    if (g < MAX_PAYLOAD) begin : g_used
      assign packed_bytes[g] = store_r[g];
    end else begin : g_zero
      assign packed_bytes[g] = '0;
    end
  end

  assign result.slot_index    = slot_r;
  assign result.type_code     = type_r;
  assign result.payload_word0 = packed_bytes[3:0];
  assign result.payload_word1 = packed_bytes[7:4];
  assign result.payload_word2 = packed_bytes[11:8];

endmodule

// ===== sv/typed_frame_receiver_unit.sv =====
// Top level of the typed frame receiver.
// The block takes one received byte per cycle as long as the result side
// does not stall it: each byte is captured in an input register, the frame
// state (hunt, type, payload) is updated for it, and a finished frame goes
// into a result register, so a result passes through the input register and
// then the result register once its closing byte is accepted. Type lookup is
// a compare of the byte against all slots at once, the lowest matching slot
// winning. The input stalls only while a result waits in the result register
// and a further byte is already held in the input register. Configuration is
// written through cfg_we, cfg_index and cfg_wdata; the user must write it
// only while no frame is in flight, as the block itself does not enforce it.
module typed_frame_receiver_unit #(
  parameter int MAX_PAYLOAD = 12,
  parameter int NUM_SLOTS   = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tfr_in_if.sink                         in_ch,
  tfr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tfr_pkg::*;

  cfg_t              cfg;
  match_t            match;
  result_t           result;
  result_t           out_data_r;
  logic              emit;
  logic              in_valid_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_valid_r;
  logic              out_free;
  logic              consume;

  tfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tfr_slot_match #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_match (
    .type_table   (cfg.type_table),
    .length_table (cfg.length_table),
    .rx_byte      (in_byte_r),
    .match        (match)
  );

  tfr_frame_fsm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (consume),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .match   (match),
    .emit    (emit),
    .result  (result)
  );

  // A held byte is processed whenever the result register can take a result.
  assign out_free    = !out_valid_r || out_ch.ready;
  assign consume     = in_valid_r && out_free;
  assign in_ch.ready = !in_valid_r || consume;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= consume && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (consume && emit) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.slot_index    = out_data_r.slot_index;
  assign out_ch.type_code     = out_data_r.type_code;
  assign out_ch.payload_word0 = out_data_r.payload_word0;
  assign out_ch.payload_word1 = out_data_r.payload_word1;
  assign out_ch.payload_word2 = out_data_r.payload_word2;

endmodule

// ===== sv/tfr_checker.sv =====
// Port-level checker for the typed frame receiver, bound to the top level.
`include "typed_frame_receiver_unit_assert.svh"

module tfr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [tfr_pkg::SLOT_W-1:0] out_slot_index,
  input logic [tfr_pkg::BYTE_W-1:0] out_type_code,
  input logic [tfr_pkg::WORD_W-1:0] out_payload_word0,
  input logic [tfr_pkg::WORD_W-1:0] out_payload_word1,
  input logic [tfr_pkg::WORD_W-1:0] out_payload_word2
);
  import tfr_pkg::*;

  // A stalled result keeps its contents.
  `TFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_slot_index) && $stable(out_type_code) && $stable(out_payload_word0) && $stable(out_payload_word1) && $stable(out_payload_word2))

  // A new result comes from an accepted byte, through the input and result registers.
  `TFR_ASSERT_SAME(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2))

  // Frames need at least three bytes, so results never come back to back.
  `TFR_ASSERT_NEXT(a_out_spacing, out_valid && out_ready, !out_valid)

  // With room on the result side the input never stalls.
  `TFR_ASSERT_SAME(a_in_ready, !out_valid || out_ready, in_ready)

endmodule

bind typed_frame_receiver_unit tfr_checker u_tfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_slot_index    (out_ch.slot_index),
  .out_type_code     (out_ch.type_code),
  .out_payload_word0 (out_ch.payload_word0),
  .out_payload_word1 (out_ch.payload_word1),
  .out_payload_word2 (out_ch.payload_word2)
);

// ===== tb/tfr_frame_checker.sv =====
// Frame predictor and result checker that watches the typed frame receiver's channels.
module tfr_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  tfr_in_if                              byte_mon,
  tfr_out_if                             result_mon,
  input  logic                           cfg_we,
  input  logic [tfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfr_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             error_count,
  output int                             frames_pending
);
  import tfr_pkg::*;

  // Shadow copy of the configuration registers.
  logic [BYTE_W-1:0]     start_code_q;
  logic [BYTE_W-1:0]     end_code_q;
  logic [TYPE_TBL_W-1:0] type_table_q;
  logic [LEN_TBL_W-1:0]  length_table_q;

  // Frame tracking state of the predictor.
  bit                hunting;
  int                position;
  int                frame_len;
  logic [SLOT_W-1:0] frame_slot;
  logic [BYTE_W-1:0] frame_type;
  logic [BYTE_W-1:0] payload [PAY_BYTES];

  // Completed frames that the block still owes, oldest first.
  result_t expected_frames [$];

  // Moves the frame state on by one accepted byte and queues a finished frame.
  task automatic advance_frame_state(input logic [BYTE_W-1:0] b);
    int      hit;
    int      i;
    result_t frame;
    if (hunting) begin
      // Every byte but the start code is ignored; the store is cleared at each start.
      if (b == start_code_q) begin
        hunting  = 1'b0;
        position = 1;
        foreach (payload[k]) payload[k] = '0;
      end
    end else if (position <= 1) begin
      // Type byte: the lowest matching slot wins, no match means back to hunting.
      hit = -1;
      for (i = 7; i >= 0; i--) begin
        if (type_table_q[8*i +: 8] == b) hit = i;
      end
      if (hit < 0) begin
        hunting  = 1'b1;
        position = 0;
      end else begin
        frame_slot = hit[SLOT_W-1:0];
        frame_type = b;
        frame_len  = int'(length_table_q[4*hit +: 4]);
        if (frame_len > PAY_BYTES) frame_len = PAY_BYTES;
        position = 2;
      end
    end else if (position >= frame_len + 2) begin
      // Closing byte: only the end code releases the frame, anything else drops it.
      if (b == end_code_q) begin
        frame.slot_index    = frame_slot;
        frame.type_code     = frame_type;
        frame.payload_word0 = {payload[3], payload[2], payload[1], payload[0]};
        frame.payload_word1 = {payload[7], payload[6], payload[5], payload[4]};
        frame.payload_word2 = {payload[11], payload[10], payload[9], payload[8]};
        expected_frames.push_back(frame);
      end
      hunting  = 1'b1;
      position = 0;
    end else begin
      payload[position-2] = b;
      position++;
    end
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  // Compares an accepted result with the oldest frame still owed.
  task automatic check_result();
    result_t want;
    if (expected_frames.size() == 0) begin
      $error("result with no frame pending: slot_index %0d, type_code 0x%02h",
             result_mon.slot_index, result_mon.type_code);
      error_count++;
    end else begin
      want = expected_frames.pop_front();
      check_field("slot_index", want.slot_index, result_mon.slot_index);
      check_field("type_code", want.type_code, result_mon.type_code);
      check_field("payload_word0", want.payload_word0, result_mon.payload_word0);
      check_field("payload_word1", want.payload_word1, result_mon.payload_word1);
      check_field("payload_word2", want.payload_word2, result_mon.payload_word2);
    end
  endtask

  // Per-edge monitor: reset, results, register writes and accepted bytes.
  always @(posedge clk) begin
    if (!rst_n) begin
      error_count    = 0;
      start_code_q   = START_CODE_RST;
      end_code_q     = END_CODE_RST;
      type_table_q   = TYPE_TBL_RST;
      length_table_q = LEN_TBL_RST;
      hunting        = 1'b1;
      position       = 0;
      frame_len      = 0;
      frame_slot     = '0;
      frame_type     = '0;
      foreach (payload[k]) payload[k] = '0;
      expected_frames.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) check_result();
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_START_CODE:   start_code_q   = cfg_wdata[BYTE_W-1:0];
          REG_END_CODE:     end_code_q     = cfg_wdata[BYTE_W-1:0];
          REG_TYPE_TABLE:   type_table_q   = cfg_wdata[TYPE_TBL_W-1:0];
          REG_LENGTH_TABLE: length_table_q = cfg_wdata[LEN_TBL_W-1:0];
          default: ;
        endcase
      end
      if (byte_mon.valid && byte_mon.ready) advance_frame_state(byte_mon.rx_byte);
    end
    frames_pending <= expected_frames.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the typed frame receiver testbench: clock, reset, stimulus and verdict.
module tb;
  import tfr_pkg::*;

  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_BYTES    = 115;
  localparam int FLUSH_LEN      = PAY_BYTES + 2;
  localparam int SETTLE_CYCLES  = 6;
  localparam int LONG_HOLD      = 80;
  localparam int WATCHDOG_LIMIT = 2000;

  // Shapes of frame that the random traffic sends.
  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_END,
    FRAME_CUT,
    FRAME_BAD_TYPE
  } frame_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    error_count;
  int                    frames_pending;
  bit                    hold_off_req;
  int                    burst_left;
  int                    bytes_sent;

  // Configuration currently loaded, used to build well-formed frames.
  logic [BYTE_W-1:0]     cur_start;
  logic [BYTE_W-1:0]     cur_end;
  logic [TYPE_TBL_W-1:0] cur_types;
  logic [LEN_TBL_W-1:0]  cur_lengths;

  tfr_in_if  in_ch ();
  tfr_out_if out_ch ();

  typed_frame_receiver_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tfr_frame_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_mon       (in_ch),
    .result_mon     (out_ch),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .error_count    (error_count),
    .frames_pending (frames_pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offers one byte and waits for its handshake; bursts are broken by random gaps.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Writes all four registers back to back; the block is idle whenever this runs.
  task automatic load_config(input logic [BYTE_W-1:0] start_code,
                             input logic [BYTE_W-1:0] end_code,
                             input logic [TYPE_TBL_W-1:0] types,
                             input logic [LEN_TBL_W-1:0] lengths);
    cur_start   = start_code;
    cur_end     = end_code;
    cur_types   = types;
    cur_lengths = lengths;
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_CODE;
    cfg_wdata <= CFG_DATA_W'(start_code);
    @(posedge clk);
    cfg_index <= REG_END_CODE;
    cfg_wdata <= CFG_DATA_W'(end_code);
    @(posedge clk);
    cfg_index <= REG_TYPE_TABLE;
    cfg_wdata <= CFG_DATA_W'(types);
    @(posedge clk);
    cfg_index <= REG_LENGTH_TABLE;
    cfg_wdata <= CFG_DATA_W'(lengths);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random tables, with duplicate type codes and oversized lengths now and then.
  task automatic random_config();
    logic [TYPE_TBL_W-1:0] types;
    logic [LEN_TBL_W-1:0]  lengths;
    int                    k;
    for (k = 0; k < 8; k++) begin
      if (k > 0 && $urandom_range(0, 3) == 0)
        types[8*k +: 8] = types[8*$urandom_range(0, k-1) +: 8];
      else
        types[8*k +: 8] = 8'($urandom_range(0, 255));
      lengths[4*k +: 4] = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(13, 15))
                                                      : 4'($urandom_range(0, 12));
    end
    load_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), types, lengths);
  endtask

  // Payload length that the block will use for a type code from the table.
  function automatic int slot_length(input logic [BYTE_W-1:0] code);
    int j;
    int len;
    len = 0;
    for (j = 7; j >= 0; j--) begin
      if (cur_types[8*j +: 8] == code) len = int'(cur_lengths[4*j +: 4]);
    end
    return (len > PAY_BYTES) ? PAY_BYTES : len;
  endfunction

  // One frame built from the current tables, intact or broken as asked.
  task automatic send_frame(input frame_kind_t kind);
    int                s;
    int                n;
    int                len;
    logic [BYTE_W-1:0] code;
    s    = $urandom_range(0, 7);
    code = cur_types[8*s +: 8];
    len  = slot_length(code);
    send_byte(cur_start);
    if (kind == FRAME_BAD_TYPE) begin
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(code);
      n = (kind == FRAME_CUT) ? $urandom_range(0, len) : len;
      // Payload bytes sometimes repeat the start code, which must count as data.
      repeat (n) send_byte(($urandom_range(0, 7) == 0) ? cur_start
                                                       : 8'($urandom_range(0, 255)));
      if (kind == FRAME_GOOD) send_byte(cur_end);
      else if (kind == FRAME_BAD_END) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly well-formed frames, the rest broken frames and line noise.
  task automatic random_traffic(input int n_bytes);
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) send_frame(FRAME_GOOD);
      else if (pick < 80) send_frame(FRAME_BAD_END);
      else if (pick < 85) send_frame(FRAME_CUT);
      else if (pick < 90) send_frame(FRAME_BAD_TYPE);
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Drives the block back to hunting with a byte that can neither open a frame
  // nor name a type, then waits for every owed result and the block's latency.
  task automatic end_phase();
    int v;
    int k;
    bit used;
    for (v = 0; v < 256; v++) begin
      used = (v[7:0] == cur_start);
      for (k = 0; k < 8; k++) begin
        if (cur_types[8*k +: 8] == v[7:0]) used = 1'b1;
      end
      if (!used) break;
    end
    repeat (FLUSH_LEN) send_byte(v[7:0]);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (frames_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Result side: a stall pattern rerolled after each pass over its 32 bits, plus one long hold-off.
  initial begin : result_drain
    logic [31:0] pattern;
    int          step;
    bit          hold_done;
    out_ch.ready <= 1'b0;
    pattern   = '1;
    step      = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        if (step == 0) begin
          case ($urandom_range(0, 3))
            0:       pattern = '1;
            1:       pattern = $urandom;
            2:       pattern = $urandom | $urandom;
            default: pattern = $urandom & $urandom;
          endcase
        end
        out_ch.ready <= pattern[step];
        step = (step + 1) % 32;
      end
    end
  end

  // Ends the run when neither channel has moved an item for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("** typed_frame_receiver_unit: FAILED **");
    $finish;
  end

  // Main sequence: reset, directed frames, then phases of random traffic.
  initial begin : stimulus
    logic [BYTE_W-1:0] directed_bytes [$];
    int                p;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_START_CODE;
    cfg_wdata     <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    hold_off_req  <= 1'b0;
    burst_left  = 0;
    bytes_sent  = 0;
    cur_start   = START_CODE_RST;
    cur_end     = END_CODE_RST;
    cur_types   = TYPE_TBL_RST;
    cur_lengths = LEN_TBL_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Slots 0 and 2 share a code, as do 3 and 6; slot 1 uses the start code as
    // its type with zero length, and slot 3 has an oversized length.
    load_config(8'h00, 8'hFF, 64'h7EFF_3021_FF10_0010, 32'h8231_F50C);
    directed_bytes = '{
      8'h55,                                 // noise while hunting
      8'h00, 8'h00, 8'hFF,                   // start code as type, empty payload
      8'h00, 8'h77,                          // unknown type
      8'h00, 8'h21, 8'h00, 8'hFF,            // start code as payload data
      8'h00, 8'h00, 8'h12,                   // empty payload, wrong end byte
      8'h00, 8'hFF,                          // duplicate code, clamped length
      8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE,
      8'h55, 8'hAA, 8'h00, 8'hFF, 8'h10, 8'hEF,
      8'hFF
    };
    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    end_phase();

    for (p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       load_config(START_CODE_RST, END_CODE_RST, TYPE_TBL_RST, LEN_TBL_RST);
        2:       load_config(8'hFF, 8'h00, '1, '1);
        3:       load_config(8'h00, 8'h00, '0, '0);
        default: random_config();
      endcase
      // Let the block fill up behind a stalled result port once.
      if (p == 1) hold_off_req <= 1'b1;
      random_traffic(PHASE_BYTES);
      end_phase();
    end

    if (error_count == 0 && frames_pending == 0)
      $display("** typed_frame_receiver_unit: PASSED **");
    else
      $display("** typed_frame_receiver_unit: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/tfr_pkg.sv
sv/tfr_in_if.sv
sv/tfr_out_if.sv
sv/tfr_cfg_regs.sv
sv/tfr_slot_match.sv
sv/tfr_frame_fsm.sv
sv/typed_frame_receiver_unit.sv
sv/tfr_checker.sv
tb/tfr_frame_checker.sv
tb/tb.sv
